// ----- hdl/atrf_pkg.sv -----
package atrf_pkg;

	// Default build widths
	localparam int TIME_BITS_DEF  = 24;
	localparam int LEVEL_BITS_DEF = 12;

	// Fixed field widths
	localparam int ELAPSED_W  = 16;
	localparam int RLEVEL_W   = 12;
	localparam int DUR_W      = 24;
	localparam int THR_W      = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ON_TIME   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_TIME  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_TIME = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RST_THR   = 2'd3;

	// Register reset values
	localparam logic [DUR_W-1:0] ON_TIME_RST   = 24'd1000;
	localparam logic [DUR_W-1:0] OFF_TIME_RST  = 24'd1000;
	localparam logic [DUR_W-1:0] EDGE_TIME_RST = 24'd10;
	localparam logic [THR_W-1:0] RST_THR_RST   = 12'd1242;

	// Phase codes
	typedef logic [1:0] phase_t;
	localparam phase_t PH_OFF     = 2'd0;
	localparam phase_t PH_RISING  = 2'd1;
	localparam phase_t PH_ON      = 2'd2;
	localparam phase_t PH_FALLING = 2'd3;

	// Phase that follows on timeout or reset
	function automatic phase_t next_phase(input phase_t ph, input logic rst);
		phase_t nxt;
		unique case (ph)
			PH_OFF:    nxt = rst ? PH_OFF : PH_RISING;
			PH_RISING: nxt = rst ? PH_FALLING : PH_ON;
			PH_ON:     nxt = PH_FALLING;
			default:   nxt = PH_OFF;
		endcase
		return nxt;
	endfunction

endpackage

// ----- hdl/atrf_ifs.sv -----
interface atrf_tick_if import atrf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [ELAPSED_W-1:0] elapsed;
	logic [RLEVEL_W-1:0]  reset_level;

	modport source (output valid, output elapsed, output reset_level, input ready);
	modport sink (input valid, input elapsed, input reset_level, output ready);
endinterface

interface atrf_result_if import atrf_pkg::*; #(
	parameter int LEVEL_BITS = LEVEL_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [LEVEL_BITS-1:0] out_level;
	phase_t                phase;

	modport source (output valid, output out_level, output phase, input ready);
	modport sink (input valid, input out_level, input phase, output ready);
endinterface

// ----- hdl/atrf_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Expects num < den * 2^Q_W so the quotient fits in Q_W bits.
module atrf_div import atrf_pkg::*; #(
	parameter int DIV_W = TIME_BITS_DEF,
	parameter int Q_W   = LEVEL_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_W+Q_W-1:0] num,
	input  logic [DIV_W-1:0]     den,
	output logic                 busy,
	output logic                 done,
	output logic [Q_W-1:0]       quo
);

	localparam int CNT_W = $clog2(Q_W + 1);

	logic [DIV_W-1:0] rem_q;
	logic [Q_W-1:0]   num_lo_q;
	logic [Q_W-1:0]   quo_q;
	logic [DIV_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DIV_W:0]   rem_sh;
	logic             fits;
	logic [DIV_W:0]   rem_sub;

	// Trial subtract of the shifted remainder
	always_comb begin
		rem_sh  = {rem_q, num_lo_q[Q_W-1]};
		fits    = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	// Control: load on start, count down the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift in one numerator bit, shift out one quotient bit
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q    <= num[DIV_W+Q_W-1:Q_W];
			num_lo_q <= num[Q_W-1:0];
			den_q    <= den;
			quo_q    <= '0;
		end else if (busy_q) begin
			rem_q    <= fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			num_lo_q <= {num_lo_q[Q_W-2:0], 1'b0};
			quo_q    <= {quo_q[Q_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

	// Remainder stays below the divisor between steps
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !$past(start) |-> rem_q < den_q || den_q == '0)
		else $error("divider remainder not below divisor");

	// Done follows the last step only
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a finished run");

	// No restart while a division is running
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start)
		else $error("divider started while busy");

endmodule

// ----- hdl/astable_timer_ramp_fsm_top.sv -----
// Astable timer phase machine: each tick word carries the elapsed time and the
// reset pin level, and yields one result word with the phase (off, rising, on,
// falling) and the output level, a ramp on the edges. Registers on_time,
// off_time and edge_time (index 0..2) hold phase durations in ticks, used in
// their low TIME_BITS bits; reset_threshold (index 3) sets the reset pin level
// that forces the machine out of the high phases. Write registers only while
// no tick is in flight. The result word of a tick is set by the ramp division,
// which produces one quotient bit per cycle; the next tick is taken in the cycle
// after the result has moved to the output register, even if that result is still
// waiting there, so a new tick is never taken before the last one is through.
module astable_timer_ramp_fsm_top import atrf_pkg::*; #(
	parameter int TIME_BITS  = TIME_BITS_DEF,
	parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	atrf_tick_if.sink             tick,
	atrf_result_if.source         result
);

	localparam int TW     = TIME_BITS + 1;
	localparam int SUM_W  = ((TW > ELAPSED_W) ? TW : ELAPSED_W) + 1;
	localparam int NUM_W  = TIME_BITS + LEVEL_BITS;
	localparam logic [TW-1:0]         TIME_MAX = '1;
	localparam logic [LEVEL_BITS-1:0] LEVEL_FS = '1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ADD  = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_PREP = 3'd3;
	localparam logic [2:0] ST_NUM  = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]            state_q;
	logic [DUR_W-1:0]      on_time_q;
	logic [DUR_W-1:0]      off_time_q;
	logic [DUR_W-1:0]      edge_time_q;
	logic [THR_W-1:0]      thr_q;
	phase_t                phase_q;
	logic [TW-1:0]         time_q;
	logic [ELAPSED_W-1:0]  elapsed_q;
	logic [RLEVEL_W-1:0]   rlevel_q;
	logic [TW-1:0]         t_q;
	logic                  rst_q;
	logic [TIME_BITS-1:0]  d_q;
	logic [TIME_BITS-1:0]  x_q;
	logic                  out_valid_q;
	logic [LEVEL_BITS-1:0] out_level_q;
	phase_t                out_phase_q;

	logic [SUM_W-1:0]      sum;
	logic [TW-1:0]         t_sat;
	logic [DUR_W-1:0]      dur_sel;
	logic [TW-1:0]         d_ext;
	logic                  advance;
	phase_t                ph_nxt;
	logic [TW-1:0]         t_nxt;
	logic [TIME_BITS-1:0]  tc;
	logic [TIME_BITS-1:0]  x_nxt;
	logic [NUM_W-1:0]      num;
	logic                  div_start;
	logic                  div_busy;
	logic                  div_done;
	logic [LEVEL_BITS-1:0] div_quo;
	logic [LEVEL_BITS-1:0] level;
	logic                  out_load;

	// Saturating time add and old phase duration
	always_comb begin
		sum   = SUM_W'(time_q) + SUM_W'(elapsed_q);
		t_sat = (sum > SUM_W'(TIME_MAX)) ? TIME_MAX : TW'(sum);
		unique case (phase_q)
			PH_ON:   dur_sel = on_time_q;
			PH_OFF:  dur_sel = off_time_q;
			default: dur_sel = edge_time_q;
		endcase
	end

	// Phase advance and time mirror
	always_comb begin
		d_ext   = TW'(d_q);
		advance = rst_q || (t_q >= d_ext);
		ph_nxt  = advance ? next_phase(phase_q, rst_q) : phase_q;
		if (!advance) begin
			t_nxt = t_q;
		end else if (rst_q && ph_nxt == PH_FALLING) begin
			t_nxt = (t_q < d_ext) ? (d_ext - t_q) : '0;
		end else begin
			t_nxt = '0;
		end
	end

	// Ramp numerator: time clipped to the duration, reversed when falling
	always_comb begin
		tc    = (time_q < d_ext) ? TIME_BITS'(time_q) : d_q;
		x_nxt = (phase_q == PH_RISING) ? tc : (d_q - tc);
		num   = {x_q, LEVEL_BITS'(0)} - NUM_W'(x_q);
	end

	assign div_start = (state_q == ST_NUM);

	atrf_div #(
		.DIV_W (TIME_BITS),
		.Q_W   (LEVEL_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (d_q),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Select the output level for the new phase
	always_comb begin
		unique case (phase_q)
			PH_ON:      level = LEVEL_FS;
			PH_RISING:  level = (d_q == '0) ? LEVEL_FS : div_quo;
			PH_FALLING: level = (d_q == '0) ? '0 : div_quo;
			default:    level = '0;
		endcase
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_time_q   <= ON_TIME_RST;
			off_time_q  <= OFF_TIME_RST;
			edge_time_q <= EDGE_TIME_RST;
			thr_q       <= RST_THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ON_TIME:   on_time_q   <= cfg_data;
				REG_OFF_TIME:  off_time_q  <= cfg_data;
				REG_EDGE_TIME: edge_time_q <= cfg_data;
				default:       thr_q       <= cfg_data[THR_W-1:0];
			endcase
		end
	end

	// Sequencer and machine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_OFF;
			time_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (tick.valid) state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					phase_q <= ph_nxt;
					time_q  <= t_nxt;
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_NUM;
				end
				ST_NUM: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && tick.valid) begin
			elapsed_q <= tick.elapsed;
			rlevel_q  <= tick.reset_level;
		end
		if (state_q == ST_ADD) begin
			t_q   <= t_sat;
			rst_q <= rlevel_q >= thr_q;
			d_q   <= TIME_BITS'(dur_sel);
		end
		if (state_q == ST_PREP) begin
			x_q <= x_nxt;
		end
		if (out_load) begin
			out_level_q <= level;
			out_phase_q <= phase_q;
		end
	end

	assign tick.ready       = (state_q == ST_IDLE);
	assign result.valid     = out_valid_q;
	assign result.out_level = out_level_q;
	assign result.phase     = out_phase_q;

	// Divider finishes only while the sequencer waits for it
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider done outside the divide state");

	// A plain advance clears the time in phase
	a_advance_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PREP && phase_q != $past(phase_q) && phase_q != PH_FALLING
		|-> time_q == '0)
		else $error("time not cleared on phase advance");

	// A finished result reaches the output register
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !out_valid_q |=> out_valid_q && state_q == ST_IDLE)
		else $error("result not moved to the output register");

	// Divider never starts while busy
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

endmodule
